@@ sv/aml_pkg.sv @@
// Shared types, constants and curve tables for the audio mix-minus soft limiter.
// No dependencies; compile before the interfaces and the modules.
`default_nettype none

package aml_pkg;

  localparam int MAX_LANES  = 8;
  localparam int SAMPLE_W   = 16;
  // sum of eight 16-bit samples needs three more bits
  localparam int SUM_W      = SAMPLE_W + 3;
  localparam int LOW_W      = 15;
  localparam int LEVEL_W    = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_OUT    = 1'd1;

  localparam logic [3:0] CHANNEL_COUNT_RESET = 4'd8;

  localparam logic [LEVEL_W-1:0] TOP_LEVEL = 3'd4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [MAX_LANES-1:0][SAMPLE_W-1:0] lanes_t;

  typedef struct packed {
    sample_t sample_7;
    sample_t sample_6;
    sample_t sample_5;
    sample_t sample_4;
    sample_t sample_3;
    sample_t sample_2;
    sample_t sample_1;
    sample_t sample_0;
  } frame_t;

  typedef struct packed {
    sample_t mixed;
    sample_t minus_7;
    sample_t minus_6;
    sample_t minus_5;
    sample_t minus_4;
    sample_t minus_3;
    sample_t minus_2;
    sample_t minus_1;
    sample_t minus_0;
  } result_t;

  function automatic lanes_t frame_lanes(input frame_t f);
    lanes_t l;
    l[0] = f.sample_0;
    l[1] = f.sample_1;
    l[2] = f.sample_2;
    l[3] = f.sample_3;
    l[4] = f.sample_4;
    l[5] = f.sample_5;
    l[6] = f.sample_6;
    l[7] = f.sample_7;
    return l;
  endfunction

  function automatic result_t pack_result(input sample_t mixed, input lanes_t minus);
    result_t r;
    r.mixed   = mixed;
    r.minus_0 = minus[0];
    r.minus_1 = minus[1];
    r.minus_2 = minus[2];
    r.minus_3 = minus[3];
    r.minus_4 = minus[4];
    r.minus_5 = minus[5];
    r.minus_6 = minus[6];
    r.minus_7 = minus[7];
    return r;
  endfunction

  // knee base per level
  function automatic logic [LOW_W-1:0] knee_base(input logic [LEVEL_W-1:0] level);
    logic [LOW_W-1:0] b;
    unique case (level)
      3'd0:    b = 15'd0;
      3'd1:    b = 15'd28672;
      3'd2:    b = 15'd32256;
      3'd3:    b = 15'd32704;
      3'd4:    b = 15'd32760;
      default: b = 15'd0;
    endcase
    return b;
  endfunction

  // right shift of the slope term per level
  function automatic logic [3:0] knee_shift(input logic [LEVEL_W-1:0] level);
    logic [3:0] s;
    unique case (level)
      3'd0:    s = 4'd3;
      3'd1:    s = 4'd6;
      3'd2:    s = 4'd9;
      3'd3:    s = 4'd12;
      3'd4:    s = 4'd15;
      default: s = 4'd15;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ sv/aml_frame_if.sv @@
// Input channel: one frame of samples per item, valid/ready handshake.
// Depends on aml_pkg.
`default_nettype none

interface aml_frame_if;
  logic            valid;
  logic            ready;
  aml_pkg::frame_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/aml_result_if.sv @@
// Output channel: mix and mix-minus results per item, valid/ready handshake.
// Depends on aml_pkg.
`default_nettype none

interface aml_result_if;
  logic             valid;
  logic             ready;
  aml_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/aml_limiter.sv @@
// Five-level piecewise soft limiter on a signed sum, sign restored at the end.
// Depends on aml_pkg; purely combinational.
`default_nettype none

module aml_limiter (
  input  wire logic signed [aml_pkg::SUM_W-1:0]    x,
  output      logic signed [aml_pkg::SAMPLE_W-1:0] y
);

  logic                               neg;
  logic [aml_pkg::SUM_W-1:0]          mag;
  logic [aml_pkg::LEVEL_W-1:0]        level;
  logic [aml_pkg::LOW_W-1:0]          low;
  logic [aml_pkg::LOW_W+2:0]          slope;
  logic [aml_pkg::LOW_W+2:0]          slope_sh;
  logic [aml_pkg::LOW_W:0]            y_mag;

  always_comb begin
    neg   = x[aml_pkg::SUM_W-1];
    mag   = neg ? aml_pkg::SUM_W'(-x) : aml_pkg::SUM_W'(x);
    // level = magnitude >> 15, clamped at the top knee
    if (mag[aml_pkg::SUM_W-1] || mag[aml_pkg::SUM_W-2]) begin
      level = aml_pkg::TOP_LEVEL;
    end else begin
      level = {1'b0, mag[aml_pkg::LOW_W+1:aml_pkg::LOW_W]};
    end
    low      = mag[aml_pkg::LOW_W-1:0];
    // 7 * low as (low << 3) - low
    slope    = {low, 3'b000} - {3'b000, low};
    slope_sh = slope >> aml_pkg::knee_shift(level);
    // never above 32766, so it fits in 16 bits
    y_mag    = {1'b0, aml_pkg::knee_base(level)} + slope_sh[aml_pkg::LOW_W:0];
    y        = neg ? -$signed(y_mag) : $signed(y_mag);
  end

endmodule

`default_nettype wire

@@ sv/audio_mix_minus_soft_limiter_core.sv @@
// Top level of the audio mix-minus soft limiter: input register, mixer and limiters,
// result register. Depends on aml_pkg, aml_frame_if, aml_result_if and aml_limiter.
`default_nettype none

// Channel   Dir  Handshake     Payload
// frame     in   valid/ready   sample_0 .. sample_7, signed 16 bit
// result    out  valid/ready   mixed, minus_0 .. minus_7, signed 16 bit
// cfg       in   cfg_we only   cfg_index (0 channel_count, 1 single_out), cfg_data
//
// Two register stages: an item is accepted into the input register, the mix, the
// mix-minus terms and the limiter curve are worked out between that register and
// the result register. One item per cycle sustained while the result is not stalled; the
// adder tree plus limiter between the two registers sets the clock.
// Synchronous reset clears both valid flags and loads channel_count 8, single_out 0.
// A stalled result holds; the input register still takes an item when the result
// register is about to empty, so full throughput needs no idle cycles.

module audio_mix_minus_soft_limiter_core #(
  parameter int CHANNELS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  aml_frame_if.sink                                frame,
  aml_result_if.source                             result,
  input  wire logic                                cfg_we,
  input  wire logic [aml_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [aml_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam logic [3:0] CH_N = 4'(CHANNELS);

  // configuration registers
  logic [3:0] channel_count;
  logic       single_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= aml_pkg::CHANNEL_COUNT_RESET;
      single_out    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aml_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data;
        aml_pkg::REG_SINGLE_OUT:    single_out    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective channel count, saturated to 1..CHANNELS
  logic [3:0] n_eff;
  always_comb begin
    if (channel_count == 4'd0) begin
      n_eff = 4'd1;
    end else if (channel_count > CH_N) begin
      n_eff = CH_N;
    end else begin
      n_eff = channel_count;
    end
  end

  // input register stage
  logic                   s1_valid;
  logic                   s1_advance;
  aml_pkg::sample_t       s1_lane [CHANNELS];
  aml_pkg::lanes_t        in_lanes;

  assign in_lanes    = aml_pkg::frame_lanes(frame.data);
  assign s1_advance  = !result.valid || result.ready;
  assign frame.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame.ready) begin
      s1_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      for (int i = 0; i < CHANNELS; i++) begin
        s1_lane[i] <= $signed(in_lanes[i]);
      end
    end
  end

  // mixer: inactive lanes count as zero
  logic [CHANNELS-1:0]                  active;
  logic signed [aml_pkg::SUM_W-1:0]     lane_ext [CHANNELS];
  logic signed [aml_pkg::SUM_W-1:0]     sum;
  logic signed [aml_pkg::SUM_W-1:0]     minus_in [CHANNELS];

  always_comb begin
    sum = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      active[i]   = 4'(i) < n_eff;
      lane_ext[i] = active[i] ? aml_pkg::SUM_W'(s1_lane[i]) : '0;
      sum         = sum + lane_ext[i];
    end
    for (int i = 0; i < CHANNELS; i++) begin
      minus_in[i] = sum - lane_ext[i];
    end
  end

  logic signed [aml_pkg::SAMPLE_W-1:0] mixed_lim;
  logic signed [aml_pkg::SAMPLE_W-1:0] minus_lim [CHANNELS];

  aml_limiter u_mix_lim (
    .x (sum),
    .y (mixed_lim)
  );

  for (genvar g = 0; g < CHANNELS; g++) begin : g_minus
    aml_limiter u_minus_lim (
      .x (minus_in[g]),
      .y (minus_lim[g])
    );
  end

  // result selection
  logic                single_lane;
  logic                minus_en;
  aml_pkg::sample_t    mixed_sel;
  aml_pkg::lanes_t     minus_sel;

  always_comb begin
    single_lane = n_eff == 4'd1;
    minus_en    = !single_out && !single_lane;
    // one channel: sample 0 passes straight through
    mixed_sel   = single_lane ? s1_lane[0] : mixed_lim;
    minus_sel   = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (minus_en && active[i]) begin
        minus_sel[i] = minus_lim[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_advance) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      result.data <= aml_pkg::pack_result(mixed_sel, minus_sel);
    end
  end

  // checks
  a_accept_fills_s1 : assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.ready) |=> s1_valid)
    else $error("accepted item did not reach the input register");

  a_s1_moves_on : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_advance) |=> result.valid)
    else $error("input register item did not reach the result register");

  a_s1_holds : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_lane[0])))
    else $error("stalled input register lost its item");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> frame.ready)
    else $error("input stalled with an empty result register");

endmodule

`default_nettype wire
